// ----- src/arcplot_pkg.sv -----
`default_nettype none

package arcplot_pkg;

	// Depth of the sine table by default: steps per full turn
	localparam int TABLE_STEPS_DFLT = 2048;

	// Widest stroke half width that is honoured; wider requests are clipped
	localparam logic [3:0] MAX_HALF_WIDTH = 4'd15;

	// Fractional bits of the sine table and of the coordinate sums
	localparam int Q_FRAC = 14;

	// Screen and band limits saturate here so that coordinates fit in 9 bits
	localparam logic [9:0] COORD_LIMIT = 10'd512;

	// Configuration register map
	typedef enum logic [2:0] {
		REG_CENTER_X       = 3'd0,
		REG_CENTER_Y       = 3'd1,
		REG_SCREEN_WIDTH   = 3'd2,
		REG_BAND_FIRST_ROW = 3'd3,
		REG_BAND_END_ROW   = 3'd4
	} cfg_reg_t;

	localparam logic [8:0] RST_CENTER_X       = 9'd120;
	localparam logic [8:0] RST_CENTER_Y       = 9'd120;
	localparam logic [9:0] RST_SCREEN_WIDTH   = 10'd240;
	localparam logic [8:0] RST_BAND_FIRST_ROW = 9'd0;
	localparam logic [9:0] RST_BAND_END_ROW   = 10'd240;

	// Settings as the plotting back end sees them, limits already saturated
	typedef struct packed {
		logic [8:0] center_x;
		logic [8:0] center_y;
		logic [9:0] width_lim;
		logic [8:0] band_first_row;
		logic [9:0] end_lim;
	} cfg_t;

	// One classified step waiting in the queue
	typedef struct packed {
		logic signed [15:0] sin_x;
		logic signed [15:0] sin_y;
		logic [7:0]         radius;
		logic [3:0]         half_width;
		logic [15:0]        color;
	} q_item_t;

endpackage

`default_nettype wire

// ----- src/arcplot_ifs.sv -----
`default_nettype none

interface arcplot_step_if;
	logic        valid;
	logic        ready;
	logic [10:0] step_index;
	logic [7:0]  radius;
	logic [3:0]  half_width;
	logic [15:0] color;

	modport source (output valid, step_index, radius, half_width, color, input ready);
	modport sink (input valid, step_index, radius, half_width, color, output ready);
endinterface

interface arcplot_pixel_if;
	logic        valid;
	logic        ready;
	logic [8:0]  pixel_x;
	logic [8:0]  pixel_y;
	logic [15:0] pixel_color;
	logic        last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

// ----- src/arcplot_front.sv -----
`default_nettype none

module arcplot_front import arcplot_pkg::*; #(
	parameter int TABLE_STEPS = TABLE_STEPS_DFLT
) (
	input  logic          clk,
	input  logic          arst_n,
	arcplot_step_if.sink  step,
	output logic          push_valid,
	input  logic          push_ready,
	output q_item_t       push_data
);

	localparam int IDX_W = $clog2(TABLE_STEPS);
	localparam int RED_W = IDX_W + 4;
	localparam int QTR_BACK = TABLE_STEPS - TABLE_STEPS / 4;

	localparam longint unsigned HALF_PI_HI = 64'h0000_0000_1921_FB54;
	localparam longint unsigned HALF_PI_LO = 64'h0000_0000_442D_1846;

	typedef logic signed [15:0] rom_t [TABLE_STEPS];

	// Q60 product, bits 123:60 of the full 128-bit result
	function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Unsigned quotient by shift and subtract, one quotient bit per pass
	function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
		longint unsigned quo, rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// floor(16384 * sin(pi/2 * u / TABLE_STEPS)), Taylor series in Q60
	function automatic logic [15:0] quarter_sine(longint unsigned u);
		longint unsigned a, qa, ra, x, x2, term, sum;
		logic neg;
		if (u == 0) return 16'd0;
		if (u >= TABLE_STEPS) return 16'd16384;
		if (3 * u == TABLE_STEPS) return 16'd8192;
		a = HALF_PI_HI * u;
		qa = a / TABLE_STEPS;
		ra = a % TABLE_STEPS;
		x = (qa << 32) + (((ra << 32) + HALF_PI_LO * u) / TABLE_STEPS);
		x2 = mul_q60(x, x);
		term = x;
		sum = x;
		neg = 1'b1;
		for (int k = 1; k < 40 && term != 0; k++) begin
			term = div_u64(mul_q60(term, x2), 64'(2 * k) * 64'(2 * k + 1));
			if (neg) sum = sum - term;
			else sum = sum + term;
			neg = !neg;
		end
		sum = sum >> 46;
		if (sum > 64'd16384) sum = 64'd16384;
		return sum[15:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		longint unsigned q, r4, u;
		logic [15:0] v;
		for (int i = 0; i < TABLE_STEPS; i++) begin
			q = (64'(i) * 4) / TABLE_STEPS;
			r4 = (64'(i) * 4) % TABLE_STEPS;
			u = q[0] ? (64'(TABLE_STEPS) - r4) : r4;
			v = quarter_sine(u);
			r[i] = (q >= 64'd2) ? (16'd0 - v) : v;
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [RED_W-1:0] red;
	logic [IDX_W-1:0] ix, iy;
	logic [IDX_W:0]   iy_sum;
	logic [3:0]       hw_sat;
	logic             accept;

	logic               valid_s1;
	logic signed [15:0] sin_x_s1, sin_y_s1;
	logic [7:0]         radius_s1;
	logic [3:0]         hw_s1;
	logic [15:0]        color_s1;

	// Index modulo table depth: quotient is at most 15 for the narrowest table
	always_comb begin
		red = RED_W'(step.step_index);
		for (int k = 3; k >= 0; k--) begin
			if (red >= (RED_W'(TABLE_STEPS) << k)) red = red - (RED_W'(TABLE_STEPS) << k);
		end
	end

	assign ix = red[IDX_W-1:0];
	assign iy_sum = {1'b0, ix} + (IDX_W + 1)'(QTR_BACK);
	assign iy = (iy_sum >= (IDX_W + 1)'(TABLE_STEPS)) ?
		IDX_W'(iy_sum - (IDX_W + 1)'(TABLE_STEPS)) : iy_sum[IDX_W-1:0];

	assign hw_sat = (step.half_width > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : step.half_width;

	assign step.ready = !valid_s1 || push_ready;
	assign accept = step.valid && step.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Two registered read ports on the sine ROM
	always_ff @(posedge clk) begin
		if (accept) begin
			sin_x_s1  <= SINE_ROM[ix];
			sin_y_s1  <= SINE_ROM[iy];
			radius_s1 <= step.radius;
			hw_s1     <= hw_sat;
			color_s1  <= step.color;
		end
	end

	assign push_valid = valid_s1;
	assign push_data = '{sin_x: sin_x_s1, sin_y: sin_y_s1, radius: radius_s1,
		half_width: hw_s1, color: color_s1};

endmodule

`default_nettype wire

// ----- src/arcplot_queue.sv -----
`default_nettype none

module arcplot_queue import arcplot_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  q_item_t push_data,
	output logic    pop_valid,
	input  logic    pop_ready,
	output q_item_t pop_data
);

	localparam int DEPTH = 2;

	q_item_t    mem_q [DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign push_ready = (count_q != 2'(DEPTH));
	assign pop_valid = (count_q != 2'd0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("queue fill count beyond depth");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue fill count lost a push");

endmodule

`default_nettype wire

// ----- src/arcplot_back.sv -----
`default_nettype none

module arcplot_back import arcplot_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  q_item_t         pop_data,
	arcplot_pixel_if.source pixel
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;

	logic signed [15:0] sin_x_q, sin_y_q;
	logic [15:0]        color_q;
	logic signed [9:0]  layer_q;
	logic [4:0]         cnt_q;

	logic               valid_s1, end_s1;
	logic signed [25:0] prod_x_s1, prod_y_s1;
	logic [15:0]        color_s1;

	logic signed [26:0] num_x, num_y, adj_x, adj_y;
	logic signed [12:0] coord_x, coord_y;
	logic               hit_x, hit_y, cand;

	logic        pend_valid_q, pend_fin_q;
	logic [8:0]  pend_x_q, pend_y_q;
	logic [15:0] pend_color_q;

	logic        out_valid_q, out_last_q;
	logic [8:0]  out_x_q, out_y_q;
	logic [15:0] out_color_q;

	logic o_free, s1_take, s1_adv, pend_out, issue;

	// Issue side: one layer a cycle into the multipliers while stage 1 can advance
	assign pop_ready = (state_q == ST_IDLE);
	assign issue = (state_q == ST_RUN) && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (pop_valid) state_q <= ST_RUN;
				ST_RUN:  if (issue && cnt_q == 5'd0) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			sin_x_q <= pop_data.sin_x;
			sin_y_q <= pop_data.sin_y;
			color_q <= pop_data.color;
			layer_q <= $signed({2'b00, pop_data.radius}) - $signed({6'd0, pop_data.half_width});
			cnt_q   <= {pop_data.half_width, 1'b0};
		end else if (issue) begin
			layer_q <= layer_q + 10'sd1;
			cnt_q   <= cnt_q - 5'd1;
		end
	end

	// Stage 1: products of the sines with the layer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (s1_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_x_s1 <= sin_x_q * layer_q;
			prod_y_s1 <= sin_y_q * layer_q;
			color_s1  <= color_q;
			end_s1    <= (cnt_q == 5'd0);
		end
	end

	// Stage 2: add the scaled centre, truncate toward zero, clip
	assign num_x = $signed({4'd0, cfg.center_x, 14'd0}) + 27'(prod_x_s1);
	assign num_y = $signed({4'd0, cfg.center_y, 14'd0}) + 27'(prod_y_s1);
	assign adj_x = num_x[26] ? num_x + 27'sd16383 : num_x;
	assign adj_y = num_y[26] ? num_y + 27'sd16383 : num_y;
	assign coord_x = adj_x[26:Q_FRAC];
	assign coord_y = adj_y[26:Q_FRAC];

	assign hit_x = !coord_x[12] && (coord_x[11:0] < {2'b00, cfg.width_lim});
	assign hit_y = !coord_y[12] && (coord_y[11:0] >= {3'b000, cfg.band_first_row})
		&& (coord_y[11:0] < {2'b00, cfg.end_lim});
	assign cand = hit_x && hit_y;

	// One surviving pixel is held back until the next survivor or the end of
	// the step shows whether it is the last one
	assign o_free = !out_valid_q || pixel.ready;
	assign pend_out = pend_valid_q && o_free && (pend_fin_q || (valid_s1 && cand));
	assign s1_take = valid_s1 && (!pend_valid_q || (!pend_fin_q && (!cand || o_free)));
	assign s1_adv = !valid_s1 || s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_fin_q   <= 1'b0;
		end else if (s1_take && cand) begin
			pend_valid_q <= 1'b1;
			pend_fin_q   <= end_s1;
		end else if (s1_take && end_s1 && pend_valid_q) begin
			pend_fin_q <= 1'b1;
		end else if (pend_out) begin
			pend_valid_q <= 1'b0;
			pend_fin_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && cand) begin
			pend_x_q     <= coord_x[8:0];
			pend_y_q     <= coord_y[8:0];
			pend_color_q <= color_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_out) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_out) begin
			out_x_q     <= pend_x_q;
			out_y_q     <= pend_y_q;
			out_color_q <= pend_color_q;
			out_last_q  <= pend_fin_q;
		end
	end

	assign pixel.valid = out_valid_q;
	assign pixel.pixel_x = out_x_q;
	assign pixel.pixel_y = out_y_q;
	assign pixel.pixel_color = out_color_q;
	assign pixel.last_pixel = out_last_q;

	a_fin_needs_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_fin_q |-> pend_valid_q)
		else $error("end-of-step mark without a held pixel");

	a_pend_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_out |=> (out_valid_q && out_last_q == $past(pend_fin_q)))
		else $error("held pixel not moved to output register");

endmodule

`default_nettype wire

// ----- src/sine_table_arc_step_plotter_core.sv -----
`default_nettype none

// Arc step plotter: draws one angular step of a thick circular stroke.
// Channels: 'step' takes a transaction of {step_index, radius, half_width,
// colour}; 'pixel' returns one transaction per surviving pixel write, with
// last_pixel set on the final one of a step. A step whose pixels all fall
// outside the screen or band returns nothing.
// Configuration: cfg_write/cfg_index/cfg_data write centre, screen width and
// band rows; unknown indexes are ignored. Write only while the block is idle.
// Flow: the front end reduces the index, reads the sine ROM at the index and a
// quarter turn back (both ports in the same cycle) and pushes the step into a
// two-entry queue. The back end pops a step, then issues one layer per cycle,
// unless the output side stalls, through a multiply stage and an add/clip stage.
// Flow control: a step holds the back end until all its layers are issued; at most
// one pixel leaves per cycle. The front end keeps accepting while the queue has room.
// Path: front ROM register, queue, step and product registers, held pixel, output
// register; a surviving pixel is held until the next survivor or its step ends.
// Stall: when pixel.ready is low, the output register, the held pixel, the
// layer pipeline and then the queue fill in turn before step.ready falls.
// Reset: registers return to centre (120,120), width 240, band rows 0..239;
// the queue empties. The sine ROM is constant and needs no clearing.
module sine_table_arc_step_plotter_core import arcplot_pkg::*; #(
	parameter int TABLE_STEPS = TABLE_STEPS_DFLT
) (
	input  logic            clk,
	input  logic            arst_n,
	arcplot_step_if.sink    step,
	arcplot_pixel_if.source pixel,
	input  logic            cfg_write,
	input  logic [2:0]      cfg_index,
	input  logic [9:0]      cfg_data
);

	logic [8:0] center_x_q, center_y_q, band_first_row_q;
	logic [9:0] screen_width_q, band_end_row_q;
	cfg_t       cfg;

	logic    push_valid, push_ready, pop_valid, pop_ready;
	q_item_t push_data, pop_data;

	// Register file; writes to unused indexes fall through the default arm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q       <= RST_CENTER_X;
			center_y_q       <= RST_CENTER_Y;
			screen_width_q   <= RST_SCREEN_WIDTH;
			band_first_row_q <= RST_BAND_FIRST_ROW;
			band_end_row_q   <= RST_BAND_END_ROW;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CENTER_X:       center_x_q <= cfg_data[8:0];
				REG_CENTER_Y:       center_y_q <= cfg_data[8:0];
				REG_SCREEN_WIDTH:   screen_width_q <= cfg_data;
				REG_BAND_FIRST_ROW: band_first_row_q <= cfg_data[8:0];
				REG_BAND_END_ROW:   band_end_row_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Limits saturate at 512 so every emitted coordinate fits in nine bits
	assign cfg.center_x = center_x_q;
	assign cfg.center_y = center_y_q;
	assign cfg.width_lim = (screen_width_q > COORD_LIMIT) ? COORD_LIMIT : screen_width_q;
	assign cfg.band_first_row = band_first_row_q;
	assign cfg.end_lim = (band_end_row_q > COORD_LIMIT) ? COORD_LIMIT : band_end_row_q;

	arcplot_front #(
		.TABLE_STEPS (TABLE_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	arcplot_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	arcplot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pixel     (pixel)
	);

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

// Testbench for sine_table_arc_step_plotter_core.
// Each step transaction accepted on the 'step' channel is run through a local
// arc plotter. That plotter has its own Q14 sine table, built in exact integer
// arithmetic, and its own copy of the registers. The pixel writes it produces
// are queued. Every pixel transaction is checked field by field against the
// oldest queued write. Registers are only written once the block has drained.
module tb;
	import arcplot_pkg::*;

	localparam int           STEPS           = TABLE_STEPS_DFLT;
	localparam longint       Q_ONE           = longint'(1) << Q_FRAC;
	localparam logic [63:0]  HALF_PI_Q60     = 64'h1921FB54442D1846;
	localparam int           SETTLE_CYCLES   = 150;    // queue + layer pipe, worst case
	localparam int           CYCLE_LIMIT     = 400000;
	localparam int           RANDOM_ITEMS    = 220;
	localparam int           RANDOM_PHASES   = 5;
	localparam int           HOLD_OFF_CYCLES = 300;
	// indexes outside the register map; writes to them must be dropped
	localparam logic [2:0]   IDX_SPARE_FIRST = 3'd5;
	localparam logic [2:0]   IDX_SPARE_MID   = 3'd6;
	localparam logic [2:0]   IDX_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [8:0]  x;
		logic [8:0]  y;
		logic [15:0] color;
		logic        last;
	} pixel_write_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_write;
	logic [2:0] cfg_index;
	logic [9:0] cfg_data;

	arcplot_step_if  step_ch ();
	arcplot_pixel_if pix_ch ();

	sine_table_arc_step_plotter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step_ch),
		.pixel     (pix_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Local copy of the register file, as the block should hold it
	logic [8:0] cx_now    = RST_CENTER_X;
	logic [8:0] cy_now    = RST_CENTER_Y;
	logic [9:0] width_now = RST_SCREEN_WIDTH;
	logic [8:0] first_now = RST_BAND_FIRST_ROW;
	logic [9:0] end_now   = RST_BAND_END_ROW;

	int sine_q14 [STEPS];
	pixel_write_t pending_pixels [$];    // pixel writes still owed by the block
	pixel_write_t due_px;

	// Idling controls, shared between the test tasks and the two channel sides
	bit src_gaps_on    = 1'b1;
	bit sink_stalls_on = 1'b1;
	int hold_request   = 0;

	int items_sent           = 0;
	int pixels_seen          = 0;
	int steps_without_pixels = 0;
	int input_stall_cycles   = 0;
	int mismatch_count       = 0;
	int cycle_count          = 0;

	// ------------------------------------------------------------------
	// Sine table: trunc(16384*sin(2*pi*i/STEPS)), Taylor series in Q60
	// ------------------------------------------------------------------
	function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// first quadrant only: u runs 0..STEPS for 0..pi/2
	function automatic int quarter_wave(logic [63:0] u);
		logic [127:0] wide;
		logic [63:0]  x, x2, term, acc;
		bit           neg;
		int           k;
		if (u == 0)
			return 0;
		if (u >= STEPS)
			return int'(Q_ONE);
		if (3 * u == STEPS)
			return int'(Q_ONE / 2);
		wide = {64'd0, HALF_PI_Q60} * {64'd0, u};
		wide = wide / STEPS;
		x    = wide[63:0];
		x2   = q60_mul(x, x);
		term = x;
		acc  = x;
		neg  = 1'b1;
		for (k = 1; k < 40 && term != 0; k++) begin
			term = q60_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
			if (neg)
				acc = acc - term;
			else
				acc = acc + term;
			neg = !neg;
		end
		acc = acc >> 46;
		if (acc > 64'(Q_ONE))
			acc = 64'(Q_ONE);
		return int'(acc);
	endfunction

	task automatic build_sine_table();
		int i, q, r4, u, v;
		for (i = 0; i < STEPS; i++) begin
			q  = (4 * i) / STEPS;
			r4 = (4 * i) % STEPS;
			u  = q[0] ? STEPS - r4 : r4;
			v  = quarter_wave(64'(u));
			sine_q14[i] = (q >= 2) ? -v : v;
		end
	endtask

	// ------------------------------------------------------------------
	// Arc plotter: queues the pixel writes one step should produce
	// ------------------------------------------------------------------
	// A survivor is held until the next one turns up, so the final write of
	// the step can carry the last flag.
	function automatic void plot_step(logic [10:0] idx, logic [7:0] rad,
		logic [3:0] hw, logic [15:0] col);
		int           ix, iy, span, d;
		longint       sx, sy, lyr, px, py, wlim, ylim;
		bit           held;
		pixel_write_t hold_px;
		ix   = idx % STEPS;
		iy   = (ix + STEPS - STEPS / 4) % STEPS;    // quarter turn back
		sx   = sine_q14[ix];
		sy   = sine_q14[iy];
		span = (hw > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : hw;
		wlim = (width_now > COORD_LIMIT) ? longint'(COORD_LIMIT) : longint'(width_now);
		ylim = (end_now > COORD_LIMIT) ? longint'(COORD_LIMIT) : longint'(end_now);
		held = 1'b0;
		for (d = -span; d <= span; d++) begin
			// layer may go to zero or below; division truncates toward zero
			lyr = longint'(rad) + d;
			py  = (longint'(cy_now) * Q_ONE + sy * lyr) / Q_ONE;
			px  = (longint'(cx_now) * Q_ONE + sx * lyr) / Q_ONE;
			if (py < longint'(first_now) || py >= ylim)
				continue;
			if (px < 0 || px >= wlim)
				continue;
			if (held)
				pending_pixels.push_back(hold_px);
			hold_px.x     = px[8:0];
			hold_px.y     = py[8:0];
			hold_px.color = col;
			hold_px.last  = 1'b0;
			held          = 1'b1;
		end
		if (held) begin
			hold_px.last = 1'b1;
			pending_pixels.push_back(hold_px);
		end else begin
			steps_without_pixels++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Step side: acceptance monitor and sender
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && step_ch.valid && step_ch.ready)
			plot_step(step_ch.step_index, step_ch.radius, step_ch.half_width, step_ch.color);
		if (arst_n && step_ch.valid && !step_ch.ready)
			input_stall_cycles++;
	end

	// Offers one step transaction and returns at the edge that takes it.
	// valid is left high so that a back-to-back step needs no second edit.
	task automatic send_step(logic [10:0] idx, logic [7:0] rad, logic [3:0] hw,
		logic [15:0] col);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			step_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		step_ch.valid      <= 1'b1;
		step_ch.step_index <= idx;
		step_ch.radius     <= rad;
		step_ch.half_width <= hw;
		step_ch.color      <= col;
		do
			@(posedge clk);
		while (!(step_ch.valid && step_ch.ready));
		items_sent++;
	endtask

	// Mostly strokes that land on screen with a few pixels of thickness;
	// one in five is raw noise over the full field ranges.
	task automatic send_random_step();
		logic [10:0] idx;
		logic [7:0]  rad;
		logic [3:0]  hw;
		logic [15:0] col;
		idx = 11'($urandom);
		col = 16'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			rad = 8'($urandom_range(1, 160));
			hw  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(0, 3));
		end else begin
			rad = 8'($urandom);
			hw  = 4'($urandom);
		end
		send_step(idx, rad, hw, col);
	endtask

	// Drops valid, waits for every owed pixel, then gives steps that produce
	// nothing time to leave the pipe. Returns on a rising edge.
	task automatic wait_idle();
		step_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Register writes; the caller lowers cfg_write after the last one
	// ------------------------------------------------------------------
	task automatic write_reg(logic [2:0] idx, logic [9:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_CENTER_X:       cx_now    = data[8:0];
			REG_CENTER_Y:       cy_now    = data[8:0];
			REG_SCREEN_WIDTH:   width_now = data;
			REG_BAND_FIRST_ROW: first_now = data[8:0];
			REG_BAND_END_ROW:   end_now   = data;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [9:0] cx, logic [9:0] cy, logic [9:0] w,
		logic [9:0] first, logic [9:0] last_row);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_BAND_FIRST_ROW, first);
		write_reg(REG_BAND_END_ROW, last_row);
	endtask

	// Bit 9 of the 9-bit registers is set at random; the block must drop it.
	task automatic program_random_settings();
		int cx, cy, w, first, last_row;
		cx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(100, 400);
		cy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(100, 400);
		w  = ($urandom_range(0, 3) == 0) ? $urandom_range(513, 1023) : $urandom_range(200, 512);
		first    = $urandom_range(0, 200);
		last_row = first + $urandom_range(100, 400);
		if ($urandom_range(0, 4) == 0)
			last_row = $urandom_range(513, 1023);
		cx    = cx | ($urandom_range(0, 1) << 9);
		cy    = cy | ($urandom_range(0, 1) << 9);
		first = first | ($urandom_range(0, 1) << 9);
		set_regs(10'(cx), 10'(cy), 10'(w), 10'(first), 10'(last_row));
	endtask

	// ------------------------------------------------------------------
	// Pixel side: ready driver and checker
	// ------------------------------------------------------------------
	// Random stall before each transaction; a hold request from a test keeps
	// ready low for a long stretch, counted here.
	initial begin
		int stall;
		pix_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = sink_stalls_on ? $urandom_range(0, 7) : 0;
			if (hold_request > 0) begin
				stall        = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				pix_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(pix_ch.valid && pix_ch.ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel write: x=%0d y=%0d color=%h last=%0b",
					pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_color, pix_ch.last_pixel);
				mismatch_count++;
			end else begin
				due_px = pending_pixels.pop_front();
				if (pix_ch.pixel_x !== due_px.x) begin
					$error("pixel_x: expected %0d, got %0d", due_px.x, pix_ch.pixel_x);
					mismatch_count++;
				end
				if (pix_ch.pixel_y !== due_px.y) begin
					$error("pixel_y: expected %0d, got %0d", due_px.y, pix_ch.pixel_y);
					mismatch_count++;
				end
				if (pix_ch.pixel_color !== due_px.color) begin
					$error("pixel_color: expected %h, got %h", due_px.color, pix_ch.pixel_color);
					mismatch_count++;
				end
				if (pix_ch.last_pixel !== due_px.last) begin
					$error("last_pixel: expected %0b, got %0b", due_px.last, pix_ch.last_pixel);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset settings: centre (120,120), 240 wide, band rows 0..239.
	// Compass points, the table ends, the widest and thinnest strokes, radius
	// zero (layers on both sides of zero) and a stroke that leaves the screen.
	task automatic test_reset_defaults();
		send_step(11'd0,    8'd100, 4'd0,  16'hFFFF);
		send_step(11'd512,  8'd100, 4'd2,  16'h0000);
		send_step(11'd1024, 8'd119, 4'd1,  16'h1234);    // straddles the band end
		send_step(11'd1536, 8'd120, 4'd3,  16'hF800);    // straddles column zero
		send_step(11'd2047, 8'd255, 4'd15, 16'h07E0);
		send_step(11'd300,  8'd0,   4'd15, 16'h001F);
		send_step(11'd700,  8'd3,   4'd9,  16'hFFFF);
		send_step(11'd256,  8'd255, 4'd0,  16'h5555);
		send_step(11'd1800, 8'd1,   4'd0,  16'hAAAA);
	endtask

	// Extreme settings, the dropped bit 9, saturating limits, spare
	// indexes that must be ignored, a one-row band and an empty band.
	task automatic test_register_map();
		wait_idle();
		// centre at the origin: negative sums must truncate toward zero
		set_regs(10'h200, 10'h200, 10'h3FF, 10'h200, 10'h3FF);
		write_reg(IDX_SPARE_FIRST, 10'h3FF);
		write_reg(IDX_SPARE_MID, 10'h000);
		write_reg(IDX_SPARE_LAST, 10'h155);
		cfg_write <= 1'b0;
		send_step(11'd600,  8'd5,   4'd5,  16'hC0DE);
		send_step(11'd1100, 8'd3,   4'd3,  16'h0F0F);
		send_step(11'd1500, 8'd2,   4'd2,  16'hF0F0);
		send_step(11'd10,   8'd200, 4'd15, 16'h8001);
		send_step(11'd520,  8'd255, 4'd15, 16'h7FFE);
		wait_idle();
		// far corner, single band row 511
		set_regs(10'd511, 10'd511, 10'd512, 10'd511, 10'd512);
		cfg_write <= 1'b0;
		send_step(11'd1536, 8'd0, 4'd2,  16'h4321);
		send_step(11'd1540, 8'd4, 4'd4,  16'hBEEF);
		send_step(11'd2040, 8'd1, 4'd15, 16'h0001);
		wait_idle();
		// band closed and no columns: nothing may come out
		set_regs(10'd120, 10'd120, 10'd0, 10'd300, 10'd100);
		cfg_write <= 1'b0;
		send_step(11'd100, 8'd50, 4'd3, 16'h1111);
		send_step(11'd900, 8'd80, 4'd7, 16'h2222);
		wait_idle();
		set_regs(10'd120, 10'd120, 10'd1, 10'd0, 10'd240);
		cfg_write <= 1'b0;
		send_step(11'd0, 8'd60, 4'd4, 16'h3333);    // every pixel lands in column 120, off the one-column screen
	endtask

	// Receiver holds off while full-thickness strokes arrive back to back, so
	// the queue fills and the step channel has to stall.
	task automatic test_backpressure();
		int n;
		wait_idle();
		set_regs(10'd256, 10'd256, 10'd512, 10'd0, 10'd512);
		cfg_write <= 1'b0;
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		hold_request   = HOLD_OFF_CYCLES;
		for (n = 0; n < 12; n++)
			send_step(11'($urandom), 8'd100, 4'd15, 16'($urandom));
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	// Random settings per phase, and the idling mix changes from one phase to the next.
	task automatic test_random_mix();
		int ph, n;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			program_random_settings();
			cfg_write <= 1'b0;
			src_gaps_on    = (ph != 1) && (ph != 2);
			sink_stalls_on = (ph != 1) && (ph != 3);
			for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
				send_random_step();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		step_ch.valid      = 1'b0;
		step_ch.step_index = '0;
		step_ch.radius     = '0;
		step_ch.half_width = '0;
		step_ch.color      = '0;
		build_sine_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_map();
		test_backpressure();
		test_random_mix();
		wait_idle();

		$display("Ran %0d step transactions (%0d drew nothing), %0d pixel writes checked",
			items_sent, steps_without_pixels, pixels_seen);
		$display("Step input stalled for %0d cycles; %0d cycles in total",
			input_stall_cycles, cycle_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/arcplot_pkg.sv
src/arcplot_ifs.sv
src/arcplot_front.sv
src/arcplot_queue.sv
src/arcplot_back.sv
src/sine_table_arc_step_plotter_core.sv
sim/tb.sv
